### rtl/core/safc_pkg.sv
// ----------------------------------------------------------------------------
// safc_pkg
// Types and constants shared by the set-associative flow cache.
// ----------------------------------------------------------------------------
package safc_pkg;

    localparam int KEY_W  = 64;
    localparam int TIME_W = 48;
    localparam int SLOT_W = 12;

    // one packet transaction on the input channel
    typedef struct packed {
        logic [KEY_W-1:0]  flow_hash;
        logic [TIME_W-1:0] packet_time;
    } t_in;

    // one result transaction on the output channel
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              evicted;
        logic [KEY_W-1:0]  evicted_hash;
    } t_out;

    // one stored cache entry
    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] last_seen;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_SCAN,
        S_RL,
        S_RR,
        S_PICK,
        S_WR,
        S_OUT
    } t_state;

endpackage

### rtl/core/safc_ram.sv
// ----------------------------------------------------------------------------
// safc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module safc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### rtl/core/set_assoc_flow_cache_heap_lru.sv
// ----------------------------------------------------------------------------
// set_assoc_flow_cache_heap_lru
// Flow cache of heap-ordered sets with oldest-first replacement.
// ----------------------------------------------------------------------------
// After reset the block clears its entry memory, one entry per cycle, and
// stalls its input meanwhile. Each packet then scans its set through the
// single memory read port, sinks through the heap one level at a time (two
// child reads and one move per level), writes the flow and presents the
// result, which is held while the output is stalled. One packet is in work
// at a time, and the block returns to idle after each result before the
// next packet is taken.
// ----------------------------------------------------------------------------
module set_assoc_flow_cache_heap_lru #(
    parameter int CACHE_ENTRIES = 4096,
    parameter int SET_WAYS      = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  safc_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output safc_pkg::t_out o_data
);
    import safc_pkg::*;

    localparam int AW = $clog2(CACHE_ENTRIES);
    localparam int WB = $clog2(SET_WAYS);
    localparam int HW = WB + 1;
    localparam logic [HW:0] WAYS = (HW+1)'(SET_WAYS);

    t_state           r_state, n_state;
    logic [AW:0]      r_clr, n_clr;
    logic [HW-1:0]    r_h, n_h;
    logic [HW-1:0]    r_i, n_i;
    logic             r_pv, n_pv;
    logic [HW-1:0]    r_pi, n_pi;
    logic             r_found, n_found;
    logic             r_empty, n_empty;
    logic [HW-1:0]    r_at, n_at;
    logic [KEY_W-1:0] r_rootkey, n_rootkey;
    t_in              r_in, n_in;
    t_entry           r_l, n_l;
    t_out             r_out, n_out;
    logic             r_ovalid, n_ovalid;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    t_entry           ram_wdata, ram_rdata;
    logic [HW-1:0]    pos, pick;
    logic [HW:0]      twice_h;
    logic             pick_right;

    // entry address of heap position h within the current set
    function automatic logic [AW-1:0] f_addr(logic [AW-WB-1:0] set, logic [HW-1:0] h);
        logic [HW-1:0] idx;
        idx = h - HW'(1);
        return {set, idx[WB-1:0]};
    endfunction

    safc_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(CACHE_ENTRIES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_out;
    assign twice_h = {r_h, 1'b0};

    // sequencer: next state, memory control and result
    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_h       = r_h;
        n_i       = r_i;
        n_pv      = 1'b0;
        n_pi      = r_pi;
        n_found   = r_found;
        n_empty   = r_empty;
        n_at      = r_at;
        n_rootkey = r_rootkey;
        n_in      = r_in;
        n_l       = r_l;
        n_out     = r_out;
        n_ovalid  = r_ovalid;
        ram_we    = 1'b0;
        ram_waddr = f_addr(r_in.flow_hash[AW-1:WB], r_h);
        ram_wdata = '0;
        ram_raddr = f_addr(r_in.flow_hash[AW-1:WB], r_i);
        pos       = r_at;
        pick      = r_h;
        pick_right = 1'b0;
        unique case (r_state)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr[AW-1:0];
                n_clr     = r_clr + (AW+1)'(1);
                if (r_clr[AW-1:0] == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_in    = i_data;
                    n_i     = HW'(SET_WAYS);
                    n_found = 1'b0;
                    n_empty = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // issue one read per cycle, check the entry read last cycle
                if (r_i != '0) begin
                    n_i  = r_i - HW'(1);
                    n_pv = 1'b1;
                    n_pi = r_i;
                end
                if (r_pv) begin
                    if (!n_found && ram_rdata.valid
                            && ram_rdata.key == r_in.flow_hash) begin
                        n_found = 1'b1;
                        n_at    = r_pi;
                    end
                    if (!r_found && !n_empty && !ram_rdata.valid) begin
                        n_empty = 1'b1;
                        if (!n_found) begin
                            n_at = r_pi;
                        end
                    end
                    if (r_pi == HW'(1)) begin
                        n_rootkey = ram_rdata.key;
                    end
                end
                // all ways checked: pick the starting position
                if (r_i == '0 && r_pv) begin
                    pos               = (n_found || n_empty) ? n_at : HW'(1);
                    n_out.hit         = n_found;
                    n_out.evicted     = !n_found && !n_empty;
                    n_out.evicted_hash = (!n_found && !n_empty) ? n_rootkey : '0;
                    n_h               = pos;
                    n_state           = ({pos, 1'b0} <= WAYS) ? S_RL : S_WR;
                end
            end
            S_RL: begin
                ram_raddr = f_addr(r_in.flow_hash[AW-1:WB], twice_h[HW-1:0]);
                n_state   = S_RR;
            end
            S_RR: begin
                ram_raddr = f_addr(r_in.flow_hash[AW-1:WB],
                                   twice_h[HW-1:0] + HW'(1));
                n_l       = ram_rdata;
                n_state   = S_PICK;
            end
            S_PICK: begin
                // move the chosen child up and follow it down
                pick_right = (twice_h + (HW+1)'(1) <= WAYS)
                          && (!r_l.valid || (ram_rdata.valid
                              && !(r_l.last_seen < ram_rdata.last_seen)));
                pick      = pick_right ? twice_h[HW-1:0] + HW'(1) : twice_h[HW-1:0];
                ram_we    = 1'b1;
                ram_wdata = pick_right ? ram_rdata : r_l;
                n_h       = pick;
                n_state   = ({pick, 1'b0} <= WAYS) ? S_RL : S_WR;
            end
            S_WR: begin
                ram_we     = 1'b1;
                ram_wdata  = '{valid: 1'b1, key: r_in.flow_hash,
                               last_seen: r_in.packet_time};
                n_out.slot = SLOT_W'(ram_waddr);
                n_ovalid   = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_ovalid = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_pv     <= n_pv;
            r_ovalid <= n_ovalid;
        end
    end

    // payload and scan bookkeeping
    always_ff @(posedge i_clk) begin
        r_h       <= n_h;
        r_i       <= n_i;
        r_pi      <= n_pi;
        r_found   <= n_found;
        r_empty   <= n_empty;
        r_at      <= n_at;
        r_rootkey <= n_rootkey;
        r_in      <= n_in;
        r_l       <= n_l;
        r_out     <= n_out;
    end

`ifndef SYNTH
    a_valid_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == S_OUT)
        else $error("result shown outside output state");
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_data.hit && o_data.evicted))
        else $error("hit and eviction together");
    a_evict_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.evicted) |-> o_data.evicted_hash == '0)
        else $error("evicted hash without eviction");
    a_sink_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PICK |-> twice_h <= WAYS)
        else $error("sinking below the leaves");
`endif

endmodule
